FILE: src/ccm_pkg.sv
// ----------------------------------------------------------------------------
// ccm_pkg
// shared constants and action codes of the coefficient companding mapper
// ----------------------------------------------------------------------------
package ccm_pkg;

    localparam int TABLE_ENTRIES = 127;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int MAG_W         = 15;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_MAP   = 2'd1;
    localparam logic [1:0] ACT_UNMAP = 2'd2;

endpackage

FILE: src/ccm_if.sv
// ----------------------------------------------------------------------------
// ccm_req_if / ccm_rsp_if
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface ccm_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [6:0]         entry_index;
    logic [14:0]        entry_value;
    logic signed [15:0] sample;
    logic [7:0]         code_in;

    modport source (output valid, action, entry_index, entry_value, sample, code_in,
                    input ready);
    modport sink   (input valid, action, entry_index, entry_value, sample, code_in,
                    output ready);
endinterface

interface ccm_rsp_if;
    logic               valid;
    logic               ready;
    logic [7:0]         code_out;
    logic signed [15:0] value_out;
    logic               bad_code;

    modport source (output valid, code_out, value_out, bad_code, input ready);
    modport sink   (input valid, code_out, value_out, bad_code, output ready);
endinterface

FILE: src/coefficient_companding_mapper.sv
// ----------------------------------------------------------------------------
// coefficient_companding_mapper
// Write, zero-sample, code-zero and out-of-range unmap requests go from idle
// straight to ST_FIN; unmap reads the table in ST_UNMAP; map scans it in ST_SCAN,
// where k (1..125) is the index where the linear table scan stops, one table read
// per cycle from the single-port magnitude memory. ST_FIN loads the output register.
// Throughput: one request in flight; a new request is taken while the
// previous response waits in the output register. Reset clears control only.
// ----------------------------------------------------------------------------
module coefficient_companding_mapper
    import ccm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    ccm_req_if.sink      i_req,
    ccm_rsp_if.source    o_rsp
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_UNMAP = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    localparam logic [IDX_W-1:0] LAST_SCAN = IDX_W'(TABLE_ENTRIES - 2);
    localparam logic [IDX_W-1:0] TOP_IDX   = IDX_W'(TABLE_ENTRIES - 1);

    logic [MAG_W-1:0] mem [TABLE_ENTRIES];

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [MAG_W-1:0] r_prev, n_prev;
    logic [15:0]      r_mag, n_mag;
    logic             r_neg, n_neg;
    logic [MAG_W-1:0] r_rdata;
    logic [7:0]       r_pcode, n_pcode;
    logic [15:0]      r_pval, n_pval;
    logic             r_pbad, n_pbad;
    logic             r_ovalid;
    logic [7:0]       r_ocode;
    logic [15:0]      r_oval;
    logic             r_obad;

    logic             accept;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [15:0]      smag;
    logic [7:0]       cmag;
    logic signed [16:0] d_lo, d_hi;
    logic [IDX_W-1:0] pick;
    logic             out_free;

    assign i_req.ready = (r_state == ST_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign out_free    = !r_ovalid || o_rsp.ready;

    assign wr_en = accept && (i_req.action == ACT_WRITE)
                   && ({1'b0, i_req.entry_index} < 8'(TABLE_ENTRIES));

    assign smag = i_req.sample[15] ? 16'(-i_req.sample) : 16'(i_req.sample);
    assign cmag = i_req.code_in[7] ? 8'(-i_req.code_in) : i_req.code_in;

    assign d_lo = $signed({1'b0, r_mag}) - $signed({2'b00, r_prev});
    assign d_hi = $signed({2'b00, r_rdata}) - $signed({1'b0, r_mag});
    assign pick = (d_lo < d_hi) ? r_idx - IDX_W'(1) : r_idx;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_prev  = r_prev;
        n_mag   = r_mag;
        n_neg   = r_neg;
        n_pcode = r_pcode;
        n_pval  = r_pval;
        n_pbad  = r_pbad;
        rd_en   = 1'b0;
        rd_addr = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_pcode = '0;
                    n_pval  = '0;
                    n_pbad  = 1'b0;
                    n_state = ST_FIN;
                    case (i_req.action)
                        ACT_MAP: begin
                            n_mag = smag;
                            n_neg = i_req.sample[15];
                            if (i_req.sample != '0) begin
                                rd_en   = 1'b1;
                                rd_addr = '0;
                                n_idx   = '0;
                                n_state = ST_SCAN;
                            end
                        end
                        ACT_UNMAP: begin
                            n_neg = i_req.code_in[7];
                            if (i_req.code_in != '0) begin
                                if (cmag >= 8'(TABLE_ENTRIES)) begin
                                    n_pbad = 1'b1;
                                end else begin
                                    rd_en   = 1'b1;
                                    rd_addr = cmag[IDX_W-1:0];
                                    n_state = ST_UNMAP;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_idx == '0) begin
                    n_prev  = r_rdata;
                    n_idx   = IDX_W'(1);
                    rd_en   = 1'b1;
                    rd_addr = IDX_W'(1);
                end else if (r_mag < {1'b0, r_rdata}) begin
                    n_pcode = r_neg ? 8'(-{1'b0, pick}) : {1'b0, pick};
                    n_state = ST_FIN;
                end else if (r_idx == LAST_SCAN) begin
                    n_pcode = r_neg ? 8'(-{1'b0, TOP_IDX}) : {1'b0, TOP_IDX};
                    n_state = ST_FIN;
                end else begin
                    n_prev  = r_rdata;
                    n_idx   = r_idx + IDX_W'(1);
                    rd_en   = 1'b1;
                    rd_addr = r_idx + IDX_W'(1);
                end
            end
            ST_UNMAP: begin
                n_pval  = r_neg ? 16'(-{1'b0, r_rdata}) : {1'b0, r_rdata};
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[i_req.entry_index] <= i_req.entry_value;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_prev  <= n_prev;
        r_mag   <= n_mag;
        r_neg   <= n_neg;
        r_pcode <= n_pcode;
        r_pval  <= n_pval;
        r_pbad  <= n_pbad;
        if (r_state == ST_FIN && out_free) begin
            r_ocode <= r_pcode;
            r_oval  <= r_pval;
            r_obad  <= r_pbad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_FIN && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid     = r_ovalid;
    assign o_rsp.code_out  = r_ocode;
    assign o_rsp.value_out = r_oval;
    assign o_rsp.bad_code  = r_obad;

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN |-> r_idx <= LAST_SCAN)
        else $error("scan index past last searched entry");

    a_bad_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_obad) |-> (r_ocode == '0 && r_oval == '0))
        else $error("flagged code with nonzero payload");

    a_zero_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.action == ACT_MAP && i_req.sample == '0) |=> r_state == ST_FIN)
        else $error("zero sample did not finish at once");

    a_unmap_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_UNMAP |=> r_state == ST_FIN)
        else $error("unmap read took more than one cycle");

    a_fin_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && out_free) |=> (r_ovalid && r_state == ST_IDLE))
        else $error("finished response not loaded into output register");

endmodule
